@@ src/rru_pkg.sv @@
// Package for the recurrent retention block: payload structs, fixed-point
// constants and queue status type. No dependencies.
package rru_pkg;

    localparam int HEAD_DIM_DEF = 4;
    localparam int NUM_OUT      = 4;
    localparam int ELEM_W       = 16;
    localparam int DECAY_W      = 16;
    localparam int ST_W         = 48;
    localparam int OUT_W        = 32;
    localparam int ACC_W        = 68;
    localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd58982;

    // Register byte address bit that selects the register index
    localparam logic REG_DECAY = 1'b0;

    typedef struct packed {
        logic              seq_start;
        logic [1:0]        elem_index;
        logic signed [15:0] q_elem;
        logic signed [15:0] k_elem;
        logic signed [15:0] v_elem;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] out_col0;
        logic signed [31:0] out_col1;
        logic signed [31:0] out_col2;
        logic signed [31:0] out_col3;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

@@ src/rru_fifo.sv @@
// Two-entry token queue between the front and back parts.
// Depends on rru_pkg.
module rru_fifo #(
    parameter int W = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic [W-1:0]           wdata,
    input  logic                   pop,
    output logic [W-1:0]           rdata,
    output rru_pkg::queue_status_t status
);
    import rru_pkg::*;

    logic [W-1:0] mem_reg [2];
    logic         wptr_reg, rptr_reg;
    logic [1:0]   count_reg;

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    assign rdata        = mem_reg[rptr_reg];
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);

endmodule

@@ src/rru_front.sv @@
// Front part: accepts element transactions, buffers q/k/v, and pushes a
// complete token into the queue. Depends on rru_pkg.
module rru_front #(
    parameter int HEAD_DIM = rru_pkg::HEAD_DIM_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  rru_pkg::in_item_t            in_data,
    input  rru_pkg::queue_status_t       q_status,
    output logic                         q_push,
    output logic [3*HEAD_DIM*16:0]       q_wdata
);
    import rru_pkg::*;

    localparam int IDX_W = $clog2(HEAD_DIM);
    localparam int VEC_W = HEAD_DIM * ELEM_W;

    logic [ELEM_W-1:0] qbuf_reg [HEAD_DIM];
    logic [ELEM_W-1:0] kbuf_reg [HEAD_DIM];
    logic [ELEM_W-1:0] vbuf_reg [HEAD_DIM];
    logic              pending_reg;

    logic              accept, in_range, is_last;
    logic [IDX_W-1:0]  idx;
    logic [VEC_W-1:0]  q_vec, k_vec, v_vec;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;
    assign in_range = (int'(in_data.elem_index) < HEAD_DIM);
    assign is_last  = (int'(in_data.elem_index) == HEAD_DIM - 1);
    assign idx      = IDX_W'(in_data.elem_index);

    // Buffer contents with the last-index transaction merged in
    always_comb
    begin
        for (int i = 0; i < HEAD_DIM; i++)
        begin
            q_vec[i*ELEM_W +: ELEM_W] = qbuf_reg[i];
            k_vec[i*ELEM_W +: ELEM_W] = kbuf_reg[i];
            v_vec[i*ELEM_W +: ELEM_W] = vbuf_reg[i];
        end
        if (int'(idx) == HEAD_DIM - 1)
        begin
            q_vec[(HEAD_DIM-1)*ELEM_W +: ELEM_W] = in_data.q_elem;
            k_vec[(HEAD_DIM-1)*ELEM_W +: ELEM_W] = in_data.k_elem;
            v_vec[(HEAD_DIM-1)*ELEM_W +: ELEM_W] = in_data.v_elem;
        end
    end

    assign q_push  = accept && is_last;
    assign q_wdata = {pending_reg | in_data.seq_start, q_vec, k_vec, v_vec};

    // Element buffers
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            qbuf_reg[idx] <= in_data.q_elem;
            kbuf_reg[idx] <= in_data.k_elem;
            vbuf_reg[idx] <= in_data.v_elem;
        end
    end

    // Sequence start flag, collected over the token
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 1'b0;
        end
        else if (accept && in_range)
        begin
            pending_reg <= is_last ? 1'b0 : (pending_reg | in_data.seq_start);
        end
    end

endmodule

@@ src/rru_back.sv @@
// Back part: sequencer around the multipliers that update the state matrix
// and form q x state, with the result register. Depends on rru_pkg.
module rru_back #(
    parameter int HEAD_DIM = rru_pkg::HEAD_DIM_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [15:0]               decay,
    input  rru_pkg::queue_status_t    q_status,
    input  logic [3*HEAD_DIM*16:0]    q_rdata,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output rru_pkg::out_item_t        out_data
);
    import rru_pkg::*;

    localparam int IDX_W = $clog2(HEAD_DIM);
    localparam int SI_W  = $clog2(HEAD_DIM * HEAD_DIM);
    localparam int VEC_W = HEAD_DIM * ELEM_W;
    localparam logic signed [65:0] ST_MAX_X = 66'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [65:0] ST_MIN_X = -ST_MAX_X - 66'sd1;
    localparam logic signed [ACC_W-1:0] OUT_MAX_X = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] OUT_MIN_X = -OUT_MAX_X - ACC_W'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_UPD_MUL, S_UPD_ACC, S_OUT_MUL, S_OUT_ACC, S_DONE
    } state_t;

    state_t                    state_reg;
    logic                      start_reg;
    logic [VEC_W-1:0]          qv_reg, kv_reg, vv_reg;
    logic [IDX_W-1:0]          a_reg, b_reg;
    logic signed [ST_W-1:0]    st_reg [HEAD_DIM*HEAD_DIM];
    logic signed [64:0]        dprod_reg;
    logic signed [31:0]        kvprod_reg;
    logic signed [63:0]        qsprod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [OUT_W-1:0]   res_reg [NUM_OUT];
    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic [SI_W-1:0]           si;
    logic signed [ST_W-1:0]    st_cur, prev;
    logic signed [15:0]        ka, vb, qa;
    logic signed [64:0]        dec;
    logic signed [65:0]        upd_sum;
    logic signed [ST_W-1:0]    upd_sat;
    logic signed [ACC_W-1:0]   acc_next, rnd;
    logic signed [OUT_W-1:0]   out_sat;
    logic                      a_last, b_last, emit;

    assign si     = SI_W'(int'(a_reg) * HEAD_DIM + int'(b_reg));
    assign st_cur = st_reg[si];
    assign prev   = start_reg ? '0 : st_cur;
    assign ka     = kv_reg[int'(a_reg)*ELEM_W +: ELEM_W];
    assign vb     = vv_reg[int'(b_reg)*ELEM_W +: ELEM_W];
    assign qa     = qv_reg[int'(a_reg)*ELEM_W +: ELEM_W];
    assign a_last = (int'(a_reg) == HEAD_DIM - 1);
    assign b_last = (int'(b_reg) == HEAD_DIM - 1);

    // State update: rounded decay plus k*v, saturated to 48 bits
    always_comb
    begin
        dec     = (dprod_reg + 65'sd32768) >>> 16;
        upd_sum = 66'(dec) + 66'(kvprod_reg);
        if (upd_sum > ST_MAX_X)
        begin
            upd_sat = ST_MAX_X[ST_W-1:0];
        end
        else if (upd_sum < ST_MIN_X)
        begin
            upd_sat = ST_MIN_X[ST_W-1:0];
        end
        else
        begin
            upd_sat = upd_sum[ST_W-1:0];
        end
    end

    // Output column: exact sum, round half up to 15 fraction bits, saturate
    always_comb
    begin
        acc_next = acc_reg + ACC_W'(qsprod_reg);
        rnd      = (acc_next + ACC_W'(64'sd536870912)) >>> 30;
        if (rnd > OUT_MAX_X)
        begin
            out_sat = OUT_MAX_X[OUT_W-1:0];
        end
        else if (rnd < OUT_MIN_X)
        begin
            out_sat = OUT_MIN_X[OUT_W-1:0];
        end
        else
        begin
            out_sat = rnd[OUT_W-1:0];
        end
    end

    assign q_pop = (state_reg == S_IDLE) && !q_status.empty;
    assign emit  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // State matrix, reset to zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEAD_DIM * HEAD_DIM; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (state_reg == S_UPD_ACC)
        begin
            st_reg[si] <= upd_sat;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                {start_reg, qv_reg, kv_reg, vv_reg} <= q_rdata;
                acc_reg <= '0;
                for (int i = 0; i < NUM_OUT; i++)
                begin
                    res_reg[i] <= '0;
                end
            end
            S_UPD_MUL:
            begin
                dprod_reg  <= prev * $signed({1'b0, decay});
                kvprod_reg <= ka * vb;
            end
            S_OUT_MUL:
            begin
                qsprod_reg <= qa * st_cur;
            end
            S_OUT_ACC:
            begin
                acc_reg <= a_last ? '0 : acc_next;
                if (a_last)
                begin
                    for (int i = 0; i < NUM_OUT; i++)
                    begin
                        if (i == int'(b_reg))
                        begin
                            res_reg[i] <= out_sat;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (emit)
        begin
            out_data_reg <= {res_reg[0], res_reg[1], res_reg[2], res_reg[3]};
        end
    end

    // Sequencer and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    a_reg <= '0;
                    b_reg <= '0;
                    if (!q_status.empty)
                    begin
                        state_reg <= S_UPD_MUL;
                    end
                end
                S_UPD_MUL:
                begin
                    state_reg <= S_UPD_ACC;
                end
                S_UPD_ACC:
                begin
                    if (b_last)
                    begin
                        b_reg <= '0;
                        if (a_last)
                        begin
                            a_reg     <= '0;
                            state_reg <= S_OUT_MUL;
                        end
                        else
                        begin
                            a_reg     <= a_reg + 1'b1;
                            state_reg <= S_UPD_MUL;
                        end
                    end
                    else
                    begin
                        b_reg     <= b_reg + 1'b1;
                        state_reg <= S_UPD_MUL;
                    end
                end
                S_OUT_MUL:
                begin
                    state_reg <= S_OUT_ACC;
                end
                S_OUT_ACC:
                begin
                    if (a_last)
                    begin
                        a_reg <= '0;
                        if (b_last)
                        begin
                            b_reg     <= '0;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            b_reg     <= b_reg + 1'b1;
                            state_reg <= S_OUT_MUL;
                        end
                    end
                    else
                    begin
                        a_reg     <= a_reg + 1'b1;
                        state_reg <= S_OUT_MUL;
                    end
                end
                S_DONE:
                begin
                    if (emit)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ src/retention_recurrent_update.sv @@
// Recurrent retention update, top level: APB decay register, front, queue
// and back. Depends on rru_pkg, rru_front, rru_fifo and rru_back.
//
// Each token arrives as HEAD_DIM element transactions; the one with the last
// index completes it and gives one result transaction. The front takes one
// element transaction per cycle while the two-token queue has room. The back
// runs every token through its multipliers in a multiply and an accumulate
// state per state entry and per q x state product, with an idle state that
// takes the token from the queue and a done state that loads the result
// register and may be held by the output stall; it takes the next token only
// after that. The state matrix resets to zero.
module retention_recurrent_update #(
    parameter int HEAD_DIM = rru_pkg::HEAD_DIM_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  rru_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output rru_pkg::out_item_t out_data
);
    import rru_pkg::*;

    localparam int TOK_W = 3 * HEAD_DIM * ELEM_W + 1;

    logic [DECAY_W-1:0] decay_reg;
    queue_status_t      q_status;
    logic               q_push, q_pop;
    logic [TOK_W-1:0]   q_wdata, q_rdata;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= DECAY_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_DECAY)
        begin
            decay_reg <= pwdata[DECAY_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_DECAY) ? {16'd0, decay_reg} : 32'd0;

    rru_front #(.HEAD_DIM(HEAD_DIM)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_status (q_status),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    rru_fifo #(.W(TOK_W)) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (q_wdata),
        .pop    (q_pop),
        .rdata  (q_rdata),
        .status (q_status)
    );

    rru_back #(.HEAD_DIM(HEAD_DIM)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .decay     (decay_reg),
        .q_status  (q_status),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // Queue never overflows or underflows
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push && !q_pop |-> !q_status.full)
        else $error("token queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("token queue underflow");

    a_status_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    // Decay register takes the written value
    a_decay_write: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == REG_DECAY
        |=> decay_reg == $past(pwdata[DECAY_W-1:0]))
        else $error("decay write lost");

endmodule
